// File: rtl/ubsm_pkg.sv
package ubsm_pkg;

  // default sizes
  localparam int unsigned MAX_SEGMENTS_DEF     = 32;
  localparam int unsigned BYTE_TABLE_DEPTH_DEF = 1024;

  // codes below this pass through when the table is off
  localparam logic [15:0] ASCII_LIMIT = 16'h0080;

  // reset value of the no-translation byte ('?')
  localparam logic [7:0] NO_XLAT_RESET = 8'd63;

  // configuration register indexes
  localparam logic [1:0] CFG_SEG_COUNT = 2'd0;
  localparam logic [1:0] CFG_NO_XLAT   = 2'd1;
  localparam logic [1:0] CFG_TBL_EN    = 2'd2;

  typedef enum logic [1:0] {
    OP_CONVERT = 2'd0,
    OP_SEG_WR  = 2'd1,
    OP_BYTE_WR = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef struct packed {
    logic [15:0] rng_start;
    logic [15:0] rng_end;
    logic [15:0] rng_delta;
  } seg_entry_t;

  // outcome of one segment search
  typedef struct packed {
    logic        hit;
    logic        fault;
    logic [16:0] idx;
  } scan_res_t;

endpackage

// File: rtl/ubsm_scan.sv
module ubsm_scan #(
  parameter int unsigned MAX_SEGMENTS     = ubsm_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned BYTE_TABLE_DEPTH = ubsm_pkg::BYTE_TABLE_DEPTH_DEF,
  parameter int unsigned SegAw            = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [15:0]          code_i,
  input  logic [5:0]           count_i,
  input  logic                 wr_en_i,
  input  logic [SegAw-1:0]     wr_slot_i,
  input  ubsm_pkg::seg_entry_t wr_entry_i,
  output logic                 done_o,
  output ubsm_pkg::scan_res_t  res_o
);
  import ubsm_pkg::*;

  localparam int unsigned CntW     = $clog2(MAX_SEGMENTS + 1);
  localparam logic [8:0]  SegLimit = 9'(MAX_SEGMENTS);

  seg_entry_t seg_mem [MAX_SEGMENTS];
  seg_entry_t entry_q;

  logic            busy_q, busy_d;
  logic            chk_q, chk_d;
  logic            done_q, done_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     code_q;
  scan_res_t       res_q, res_d;

  logic [8:0]  cnt_sat;
  logic        issue;
  logic        in_rng;
  logic        hit_now;
  logic [17:0] idx_sum;
  logic        idx_over;

  // shared compare and add unit, one stored segment per cycle
  always_comb begin
    cnt_sat  = (9'(count_i) > SegLimit) ? SegLimit : 9'(count_i);
    issue    = busy_q && (ptr_q != cnt_q);
    in_rng   = (code_q >= entry_q.rng_start) && (code_q <= entry_q.rng_end);
    idx_sum  = {2'b00, code_q} + {{2{entry_q.rng_delta[15]}}, entry_q.rng_delta};
    idx_over = !idx_sum[17] && (idx_sum[16:0] >= 17'(BYTE_TABLE_DEPTH));
    hit_now  = busy_q && chk_q && in_rng;
  end

  always_comb begin
    busy_d = busy_q;
    ptr_d  = ptr_q;
    cnt_d  = cnt_q;
    chk_d  = issue;
    done_d = 1'b0;
    res_d  = res_q;
    priority if (start_i) begin
      busy_d = 1'b1;
      ptr_d  = '0;
      cnt_d  = CntW'(cnt_sat);
      chk_d  = 1'b0;
      res_d  = '0;
    end else if (hit_now) begin
      // first matching segment ends the search
      busy_d    = 1'b0;
      chk_d     = 1'b0;
      done_d    = 1'b1;
      res_d.hit   = 1'b1;
      res_d.fault = idx_sum[17] || idx_over;
      res_d.idx   = idx_sum[16:0];
    end else if (busy_q && !issue) begin
      // all segments checked, none matched
      busy_d    = 1'b0;
      chk_d     = 1'b0;
      done_d    = 1'b1;
      res_d.hit   = 1'b0;
      res_d.fault = 1'b0;
    end else if (issue) begin
      ptr_d = ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      done_q <= 1'b0;
      ptr_q  <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      chk_q  <= chk_d;
      done_q <= done_d;
      ptr_q  <= ptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (start_i) begin
      code_q <= code_i;
    end
  end

  // segment store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      seg_mem[wr_slot_i] <= wr_entry_i;
    end
    if (issue) begin
      entry_q <= seg_mem[ptr_q[SegAw-1:0]];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ptr_q <= cnt_q)
    else $error("segment pointer ran past count");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("search reported done while still busy");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("search started while busy");

endmodule

// File: rtl/unicode_to_byte_segment_map.sv
// flow: writes, no-ops and passthrough set the pending result, then load the output register;
// a lookup searches the segments in order and a usable hit then reads the byte table, while a
// miss or an index outside the table does not; up to n = min(segment_count, MAX_SEGMENTS)
// segments are searched, one segment read per cycle; one item at a time, next transfer in the
//   cycle after the result loads, later while a result waits for out_ready_i
// reset: config to count 0, no-translation byte 63, table off; stores undefined until written
module unicode_to_byte_segment_map #(
  parameter int unsigned MAX_SEGMENTS     = ubsm_pkg::MAX_SEGMENTS_DEF,
  parameter int unsigned BYTE_TABLE_DEPTH = ubsm_pkg::BYTE_TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] code_unit_i,
  input  logic [9:0]  slot_i,
  input  logic [15:0] range_start_i,
  input  logic [15:0] range_end_i,
  input  logic signed [15:0] range_delta_i,
  input  logic [7:0]  table_byte_i,
  input  logic        last_in_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        matched_o,
  output logic        index_fault_o,
  output logic        last_out_o
);
  import ubsm_pkg::*;

  localparam int unsigned SegAw  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned ByteAw = $clog2(BYTE_TABLE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_READ = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [5:0] seg_cnt_q;
  logic [7:0] no_xlat_q;
  logic       tbl_en_q;

  // result being built for the current item
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       pend_match_q, pend_match_d;
  logic       pend_fault_q, pend_fault_d;
  logic       pend_last_q, pend_last_d;

  // output register, frees the input side while a result waits
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_match_q;
  logic       out_fault_q;
  logic       out_last_q;

  // byte table
  logic [7:0] byte_mem [BYTE_TABLE_DEPTH];
  logic [7:0] byte_rd_q;

  op_e        op;
  logic       accept;
  logic       scan_start;
  logic       seg_wr;
  logic       byte_wr;
  logic       byte_rd;
  logic       out_load;
  logic       scan_done;
  scan_res_t  scan_res;
  seg_entry_t seg_wr_entry;

  assign op         = op_e'(opcode_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign scan_start = accept && (op == OP_CONVERT) && tbl_en_q;
  // out-of-range write slots are dropped
  assign seg_wr     = accept && (op == OP_SEG_WR) && ({7'b0, slot_i} < 17'(MAX_SEGMENTS));
  assign byte_wr    = accept && (op == OP_BYTE_WR)
                      && ({7'b0, slot_i} < 17'(BYTE_TABLE_DEPTH));
  // a usable hit fetches its byte from the table
  assign byte_rd    = (state_q == ST_SCAN) && scan_done && scan_res.hit && !scan_res.fault;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  assign seg_wr_entry.rng_start = range_start_i;
  assign seg_wr_entry.rng_end   = range_end_i;
  assign seg_wr_entry.rng_delta = range_delta_i;

  ubsm_scan #(
    .MAX_SEGMENTS     (MAX_SEGMENTS),
    .BYTE_TABLE_DEPTH (BYTE_TABLE_DEPTH),
    .SegAw            (SegAw)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .code_i     (code_unit_i),
    .count_i    (seg_cnt_q),
    .wr_en_i    (seg_wr),
    .wr_slot_i  (slot_i[SegAw-1:0]),
    .wr_entry_i (seg_wr_entry),
    .done_o     (scan_done),
    .res_o      (scan_res)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    pend_byte_d  = pend_byte_q;
    pend_match_d = pend_match_q;
    pend_fault_d = pend_fault_q;
    pend_last_d  = pend_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // writes and no-ops answer with a zero byte and zero match and fault flags
          pend_byte_d  = 8'd0;
          pend_match_d = 1'b0;
          pend_fault_d = 1'b0;
          pend_last_d  = last_in_i;
          state_d      = ST_OUT;
          if (op == OP_CONVERT) begin
            if (tbl_en_q) begin
              state_d = ST_SCAN;
            end else if (code_unit_i < ASCII_LIMIT) begin
              // plain ascii passes straight through
              pend_byte_d  = code_unit_i[7:0];
              pend_match_d = 1'b1;
            end else begin
              pend_byte_d = no_xlat_q;
            end
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (byte_rd) begin
            state_d = ST_READ;
          end else begin
            // no segment, or index outside the table
            pend_byte_d  = no_xlat_q;
            pend_match_d = 1'b0;
            pend_fault_d = scan_res.fault;
            state_d      = ST_OUT;
          end
        end
      end
      ST_READ: begin
        pend_byte_d  = byte_rd_q;
        pend_match_d = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration, index 3 is unused
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_cnt_q <= 6'd0;
      no_xlat_q <= NO_XLAT_RESET;
      tbl_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SEG_COUNT: seg_cnt_q <= cfg_data_i[5:0];
        CFG_NO_XLAT:   no_xlat_q <= cfg_data_i;
        CFG_TBL_EN:    tbl_en_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_byte_q  <= pend_byte_d;
    pend_match_q <= pend_match_d;
    pend_fault_q <= pend_fault_d;
    pend_last_q  <= pend_last_d;
    if (out_load) begin
      out_byte_q  <= pend_byte_q;
      out_match_q <= pend_match_q;
      out_fault_q <= pend_fault_q;
      out_last_q  <= pend_last_q;
    end
  end

  // byte table, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (byte_wr) begin
      byte_mem[ByteAw'(slot_i)] <= table_byte_i;
    end
    if (byte_rd) begin
      byte_rd_q <= byte_mem[scan_res.idx[ByteAw-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign matched_o     = out_match_q;
  assign index_fault_o = out_fault_q;
  assign last_out_o    = out_last_q;

  a_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |-> state_q == ST_SCAN)
    else $error("segment search finished outside the search state");

  a_read_after_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> $past(byte_rd))
    else $error("byte table read without a usable hit");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o && state_q == ST_IDLE)
    else $error("result transfer not presented after load");

  a_match_xor_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(matched_o && index_fault_o))
    else $error("result both matched and faulted");

endmodule
